### src/compact_target_codec_core_defines.svh
// ----------------------------------------------------------------------------
// Compact target codec: assertion macros
// Shared concurrent-assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef COMPACT_TARGET_CODEC_CORE_DEFINES_SVH
`define COMPACT_TARGET_CODEC_CORE_DEFINES_SVH

// Same-cycle implication
`define CTC_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ctc_pkg.sv
// ----------------------------------------------------------------------------
// Compact target codec package
// Transfer types and operation codes shared by the codec core.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Mantissa constants of the compact form
  localparam logic [23:0] MANT_TOP_BIT = 24'h800000;
  localparam logic [23:0] MANT_MASK    = 24'hFFFFFF;

  // Highest exponent that still lands a mantissa byte inside 256 bits
  localparam logic [7:0] DEC_EXP_MAX = 8'd34;

  // Request transfer
  typedef struct packed {
    logic        operation;
    logic [63:0] target_word_0;
    logic [63:0] target_word_1;
    logic [63:0] target_word_2;
    logic [63:0] target_word_3;
    logic [31:0] compact_in;
  } ctc_in_t;

  // Result transfer
  typedef struct packed {
    logic [31:0] compact_out;
    logic [63:0] value_word_0;
    logic [63:0] value_word_1;
    logic [63:0] value_word_2;
    logic [63:0] value_word_3;
  } ctc_out_t;

endpackage

### src/compact_target_codec_core.sv
// ----------------------------------------------------------------------------
// Compact target codec core
// Converts a 256-bit target to its 32-bit compact form or back, per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid_i / in_stall_o / in_data_i carries one operation
//   with either a 256-bit target (encode) or a compact word (decode).
//   Result channel out_valid_o / out_stall_i / out_data_o returns exactly one
//   result per request, in order; fields of the unused direction are zero.
//   A transfer completes on a rising edge with valid high and stall low.
// Path: a request passes the input register, conversion logic and result
//   register before its result is valid.
// Throughput: one transfer per cycle unless out_stall_i holds the result channel; the
//   conversion is a single pass of byte search, byte select and barrel shift between the two registers.
// Stall: when out_stall_i holds a waiting result, the input register still
//   fills; in_stall_o rises only once both registers hold items.
// Reset: rst_ni clears both valid flags asynchronously; no items are lost
//   or invented afterwards. The block keeps no other state.
// ----------------------------------------------------------------------------
module compact_target_codec_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ctc_pkg::ctc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ctc_pkg::ctc_out_t out_data_o
);
  import ctc_pkg::*;

  logic     s1_valid_q;
  ctc_in_t  s1_data_q;
  logic     out_valid_q;
  ctc_out_t out_data_q;
  ctc_out_t res_d;

  logic adv_out;
  logic adv_s1;

  // Pipeline advance
  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_s1     = !s1_valid_q || adv_out;
  assign in_stall_o = !adv_s1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // Encode: find leading nonzero byte
  logic [255:0] enc_tgt;
  logic [5:0]   enc_len;
  logic [4:0]   enc_lenm1;
  logic [271:0] enc_ext;
  logic [23:0]  enc_mant_raw;
  logic [23:0]  enc_mant;
  logic [5:0]   enc_exp;
  logic [31:0]  enc_compact;

  assign enc_tgt = {s1_data_q.target_word_3, s1_data_q.target_word_2,
                    s1_data_q.target_word_1, s1_data_q.target_word_0};

  always_comb begin
    enc_len = '0;
    for (int j = 0; j < 32; j++) begin
      if (enc_tgt[8*j +: 8] != 8'h00) begin
        enc_len = 6'(j + 1);
      end
    end
  end

  // Take three bytes from the leading byte down, zero-padded below byte 0
  assign enc_lenm1    = 5'(enc_len - 6'd1);
  assign enc_ext      = {enc_tgt, 16'h0000};
  assign enc_mant_raw = enc_ext[{enc_lenm1, 3'b000} +: 24];

  // Keep the mantissa positive: shift right a byte and bump the exponent
  always_comb begin
    if ((enc_mant_raw & MANT_TOP_BIT) != 24'h0) begin
      enc_mant = {8'h00, enc_mant_raw[23:8]};
      enc_exp  = enc_len + 6'd1;
    end else begin
      enc_mant = enc_mant_raw;
      enc_exp  = enc_len;
    end
    if (enc_len == 6'd0) begin
      enc_compact = '0;
    end else begin
      enc_compact = {2'b00, enc_exp, enc_mant & MANT_MASK};
    end
  end

  // Decode: place mantissa at byte exponent-3, truncated to 256 bits
  logic [7:0]   dec_exp;
  logic [23:0]  dec_mant;
  logic [279:0] dec_base;
  logic [279:0] dec_shift;
  logic [255:0] dec_value;

  assign dec_exp   = s1_data_q.compact_in[31:24];
  assign dec_mant  = s1_data_q.compact_in[23:0] & MANT_MASK;
  assign dec_base  = {256'h0, dec_mant};
  assign dec_shift = dec_base << {dec_exp[5:0], 3'b000};

  always_comb begin
    if (dec_exp > DEC_EXP_MAX) begin
      dec_value = '0;
    end else begin
      dec_value = dec_shift[279:24];
    end
  end

  // Select result by operation
  always_comb begin
    res_d = '0;
    case (s1_data_q.operation)
      OP_ENCODE: begin
        res_d.compact_out = enc_compact;
      end
      OP_DECODE: begin
        res_d.value_word_0 = dec_value[63:0];
        res_d.value_word_1 = dec_value[127:64];
        res_d.value_word_2 = dec_value[191:128];
        res_d.value_word_3 = dec_value[255:192];
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
`include "compact_target_codec_core_defines.svh"

  `CTC_ASSERT_NEXT(a_in_capture, in_valid_i && !in_stall_o, s1_valid_q, "request transfer lost")
  `CTC_ASSERT_IMPLIES(a_stall_full, in_stall_o, s1_valid_q && out_valid_q, "stall with room")
  `CTC_ASSERT_IMPLIES(a_exp_range, out_valid_o, out_data_o.compact_out[31:24] <= 8'd33, "exponent above 33")
  `CTC_ASSERT_IMPLIES(a_enc_clean, out_valid_o && (out_data_o.compact_out != 32'h0), (out_data_o.value_word_0 == 64'h0) && (out_data_o.value_word_3 == 64'h0), "encode result carries value")

endmodule
